// ===== rtl/psv_pkg.sv =====
package psv_pkg;

	// jones parts, q1.15
	localparam int JW = 16;
	// conjugated jones parts carry +1.0 exactly
	localparam int CW = JW + 1;
	// coherency register width, q11.12
	localparam int RW = 24;
	// coherency parts after negation of the cross term
	localparam int SW = RW + 1;
	// coherency by conjugated jones product
	localparam int PW = SW + CW;
	// one element of s * conj(r)^T, sum of three products
	localparam int FW = PW + 2;
	// left jones by intermediate element product
	localparam int MW = JW + FW;
	// one visibility part, sum of four products
	localparam int VW = MW + 2;
	// fraction bits dropped when rounding to q19.12
	localparam int DROP = 30;
	// output part width
	localparam int OW = 32;

	// number of matrix elements
	localparam int NE = 4;

	// configuration port
	localparam int CFG_IW = 8;
	localparam logic [CFG_IW-1:0] REG_COH_XX       = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_COH_CROSS_RE = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_COH_CROSS_IM = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_COH_YY       = CFG_IW'(3);

	typedef struct packed {
		logic signed [JW-1:0] re;
		logic signed [JW-1:0] im;
	} jones_t;

	typedef struct packed {
		logic signed [CW-1:0] re;
		logic signed [CW-1:0] im;
	} conj_t;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} coh_t;

	typedef struct packed {
		logic signed [FW-1:0] re;
		logic signed [FW-1:0] im;
	} fsum_t;

	typedef struct packed {
		logic signed [VW-1:0] re;
		logic signed [VW-1:0] im;
	} vsum_t;

	// real part in the upper half, imaginary in the lower
	function automatic jones_t unpack_jones(input logic [2*JW-1:0] w);
		jones_t j;
		j.re = w[2*JW-1:JW];
		j.im = w[JW-1:0];
		return j;
	endfunction

	function automatic conj_t conj_jones(input jones_t j);
		conj_t c;
		c.re = CW'(j.re);
		c.im = -CW'(j.im);
		return c;
	endfunction

endpackage

// ===== rtl/psv_if.sv =====
// cell stream: left and right jones matrices of one cell
interface psv_cell_if;
	import psv_pkg::*;
	logic            valid;
	logic            ready;
	logic [2*JW-1:0] left_a;
	logic [2*JW-1:0] left_b;
	logic [2*JW-1:0] left_c;
	logic [2*JW-1:0] left_d;
	logic [2*JW-1:0] right_a;
	logic [2*JW-1:0] right_b;
	logic [2*JW-1:0] right_c;
	logic [2*JW-1:0] right_d;
	logic            cell_last;

	modport source (
		output valid, left_a, left_b, left_c, left_d,
		output right_a, right_b, right_c, right_d, cell_last,
		input  ready
	);
	modport sink (
		input  valid, left_a, left_b, left_c, left_d,
		input  right_a, right_b, right_c, right_d, cell_last,
		output ready
	);
endinterface

// visibility stream: four predicted visibilities of one cell
interface psv_vis_if;
	import psv_pkg::*;
	logic            valid;
	logic            ready;
	logic [2*OW-1:0] vis_xx;
	logic [2*OW-1:0] vis_xy;
	logic [2*OW-1:0] vis_yx;
	logic [2*OW-1:0] vis_yy;
	logic            out_last;

	modport source (
		output valid, vis_xx, vis_xy, vis_yx, vis_yy, out_last,
		input  ready
	);
	modport sink (
		input  valid, vis_xx, vis_xy, vis_yx, vis_yy, out_last,
		output ready
	);
endinterface

// coherency register writes
interface psv_cfg_if;
	import psv_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [RW-1:0]     data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== rtl/psv_round_sat.sv =====
module psv_round_sat (
	input  logic signed [psv_pkg::VW-1:0] x,
	output logic        [psv_pkg::OW-1:0] q
);
	import psv_pkg::*;

	localparam int QW = VW + 1 - DROP;
	localparam logic signed [VW:0] HALF = (VW + 1)'(1) << (DROP - 1);
	localparam logic signed [QW-1:0] QMAX = {{(QW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN = {{(QW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

	logic signed [VW:0]   y;
	logic signed [VW:0]   y_sh;
	logic signed [QW-1:0] q_full;

	// add half an lsb, then floor: ties go towards plus infinity
	assign y      = (VW + 1)'(x) + HALF;
	assign y_sh   = y >>> DROP;
	assign q_full = y_sh[QW-1:0];

	// clamp to the signed output range
	always_comb begin
		if (q_full > QMAX) begin
			q = QMAX[OW-1:0];
		end else if (q_full < QMIN) begin
			q = QMIN[OW-1:0];
		end else begin
			q = q_full[OW-1:0];
		end
	end

endmodule

// ===== rtl/point_source_visibility_predict.sv =====
// Point-source visibility predictor: V = L * S * conj(R)^T per cell.
// cell_in carries one cell per item: left and right 2x2 Jones matrices
// (q1.15 real/imaginary pairs) and a last flag. vis_out returns one item
// per cell: four visibilities, each a signed q19.12 real/imaginary pair,
// rounded to nearest and saturated, with the last flag copied through.
// cfg writes the coherency registers coh_xx, coh_cross_re, coh_cross_im
// and coh_yy at indexes 0 to 3; other indexes are ignored. cfg is always
// ready; write it only while no cells are in flight.
// Five register stages: coherency products, sums into S * conj(R)^T,
// left Jones products, sums of four, rounding into the output register.
// An accepted item passes through the stage registers in order and is shown on vis_out from the last one.
// Throughput is one cell per cycle while vis_out is ready, set by the fully parallel multipliers.
// Each stage holds its item while the stage after it is full and blocked,
// so a stall on vis_out fills the bubbles before cell_in.ready drops.
// Reset clears the coherency registers to zero and empties the pipeline.
module point_source_visibility_predict (
	input  logic          clk,
	input  logic          arst_n,
	psv_cfg_if.sink       cfg,
	psv_cell_if.sink      cell_in,
	psv_vis_if.source     vis_out
);
	import psv_pkg::*;

	// coherency registers
	logic signed [RW-1:0] coh_xx_q;
	logic signed [RW-1:0] coh_cross_re_q;
	logic signed [RW-1:0] coh_cross_im_q;
	logic signed [RW-1:0] coh_yy_q;

	// stage valids and enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	// stage 1 operands and products
	jones_t               l_in [NE];
	conj_t                c_in [NE];
	coh_t                 s_cross;
	coh_t                 s_cross_conj;
	coh_t                 sc [NE];
	logic signed [SW-1:0] sr [NE];
	conj_t                xc [NE];
	conj_t                xr [NE];

	jones_t               l_s1   [NE];
	logic signed [PW-1:0] rr_s1  [NE];
	logic signed [PW-1:0] ri_s1  [NE];
	logic signed [PW-1:0] crr_s1 [NE];
	logic signed [PW-1:0] cii_s1 [NE];
	logic signed [PW-1:0] cri_s1 [NE];
	logic signed [PW-1:0] cir_s1 [NE];

	// stage 2 intermediate matrix
	jones_t l_s2 [NE];
	fsum_t  f_s2 [NE];

	// stage 3 left jones products
	logic signed [MW-1:0] arr_s3 [NE];
	logic signed [MW-1:0] aii_s3 [NE];
	logic signed [MW-1:0] ari_s3 [NE];
	logic signed [MW-1:0] air_s3 [NE];
	logic signed [MW-1:0] brr_s3 [NE];
	logic signed [MW-1:0] bii_s3 [NE];
	logic signed [MW-1:0] bri_s3 [NE];
	logic signed [MW-1:0] bir_s3 [NE];

	// stage 4 visibility sums
	vsum_t v_s4 [NE];

	// stage 5 output register
	logic [OW-1:0]   q_re [NE];
	logic [OW-1:0]   q_im [NE];
	logic [2*OW-1:0] vis_s5 [NE];

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coh_xx_q       <= '0;
			coh_cross_re_q <= '0;
			coh_cross_im_q <= '0;
			coh_yy_q       <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_COH_XX:       coh_xx_q       <= cfg.data;
				REG_COH_CROSS_RE: coh_cross_re_q <= cfg.data;
				REG_COH_CROSS_IM: coh_cross_im_q <= cfg.data;
				REG_COH_YY:       coh_yy_q       <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	assign en_s5 = !valid_s5 || vis_out.ready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign cell_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= cell_in.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// unpack the cell and conjugate the right matrix
	always_comb begin
		l_in[0] = unpack_jones(cell_in.left_a);
		l_in[1] = unpack_jones(cell_in.left_b);
		l_in[2] = unpack_jones(cell_in.left_c);
		l_in[3] = unpack_jones(cell_in.left_d);
		c_in[0] = conj_jones(unpack_jones(cell_in.right_a));
		c_in[1] = conj_jones(unpack_jones(cell_in.right_b));
		c_in[2] = conj_jones(unpack_jones(cell_in.right_c));
		c_in[3] = conj_jones(unpack_jones(cell_in.right_d));
	end

	// coherency terms: s2 and its conjugate s3
	always_comb begin
		s_cross.re      = SW'(coh_cross_re_q);
		s_cross.im      = SW'(coh_cross_im_q);
		s_cross_conj.re = SW'(coh_cross_re_q);
		s_cross_conj.im = -SW'(coh_cross_im_q);
	end

	// each element of S * conj(R)^T is a complex term plus a real term
	always_comb begin
		sc[0] = s_cross;      xc[0] = c_in[1]; sr[0] = SW'(coh_xx_q); xr[0] = c_in[0];
		sc[1] = s_cross;      xc[1] = c_in[3]; sr[1] = SW'(coh_xx_q); xr[1] = c_in[2];
		sc[2] = s_cross_conj; xc[2] = c_in[0]; sr[2] = SW'(coh_yy_q); xr[2] = c_in[1];
		sc[3] = s_cross_conj; xc[3] = c_in[2]; sr[3] = SW'(coh_yy_q); xr[3] = c_in[3];
	end

	// stage 1: coherency products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			last_s1 <= cell_in.cell_last;
			for (int k = 0; k < NE; k++) begin
				l_s1[k]   <= l_in[k];
				rr_s1[k]  <= sr[k] * xr[k].re;
				ri_s1[k]  <= sr[k] * xr[k].im;
				crr_s1[k] <= sc[k].re * xc[k].re;
				cii_s1[k] <= sc[k].im * xc[k].im;
				cri_s1[k] <= sc[k].re * xc[k].im;
				cir_s1[k] <= sc[k].im * xc[k].re;
			end
		end
	end

	// stage 2: sums into the intermediate matrix
	always_ff @(posedge clk) begin
		if (en_s2) begin
			last_s2 <= last_s1;
			for (int k = 0; k < NE; k++) begin
				l_s2[k]    <= l_s1[k];
				f_s2[k].re <= FW'(rr_s1[k]) + FW'(crr_s1[k]) - FW'(cii_s1[k]);
				f_s2[k].im <= FW'(ri_s1[k]) + FW'(cri_s1[k]) + FW'(cir_s1[k]);
			end
		end
	end

	// stage 3: left jones products, row of L by column of the intermediate
	always_ff @(posedge clk) begin
		if (en_s3) begin
			last_s3 <= last_s2;
			for (int o = 0; o < NE; o++) begin
				arr_s3[o] <= l_s2[2'(o & 2)].re * f_s2[2'(o & 1)].re;
				aii_s3[o] <= l_s2[2'(o & 2)].im * f_s2[2'(o & 1)].im;
				ari_s3[o] <= l_s2[2'(o & 2)].re * f_s2[2'(o & 1)].im;
				air_s3[o] <= l_s2[2'(o & 2)].im * f_s2[2'(o & 1)].re;
				brr_s3[o] <= l_s2[2'((o & 2) + 1)].re * f_s2[2'(2 + (o & 1))].re;
				bii_s3[o] <= l_s2[2'((o & 2) + 1)].im * f_s2[2'(2 + (o & 1))].im;
				bri_s3[o] <= l_s2[2'((o & 2) + 1)].re * f_s2[2'(2 + (o & 1))].im;
				bir_s3[o] <= l_s2[2'((o & 2) + 1)].im * f_s2[2'(2 + (o & 1))].re;
			end
		end
	end

	// stage 4: sums of four products per part
	always_ff @(posedge clk) begin
		if (en_s4) begin
			last_s4 <= last_s3;
			for (int o = 0; o < NE; o++) begin
				v_s4[o].re <= VW'(arr_s3[o]) - VW'(aii_s3[o])
					+ VW'(brr_s3[o]) - VW'(bii_s3[o]);
				v_s4[o].im <= VW'(ari_s3[o]) + VW'(air_s3[o])
					+ VW'(bri_s3[o]) + VW'(bir_s3[o]);
			end
		end
	end

	// rounding and saturation of every part
	for (genvar o = 0; o < NE; o++) begin : g_round
		psv_round_sat u_round_re (
			.x (v_s4[o].re),
			.q (q_re[o])
		);
		psv_round_sat u_round_im (
			.x (v_s4[o].im),
			.q (q_im[o])
		);
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (en_s5) begin
			last_s5 <= last_s4;
			for (int o = 0; o < NE; o++) begin
				vis_s5[o] <= {q_re[o], q_im[o]};
			end
		end
	end

	assign vis_out.valid    = valid_s5;
	assign vis_out.vis_xx   = vis_s5[0];
	assign vis_out.vis_xy   = vis_s5[1];
	assign vis_out.vis_yx   = vis_s5[2];
	assign vis_out.vis_yy   = vis_s5[3];
	assign vis_out.out_last = last_s5;

endmodule
